// File: design/tlc_pkg.sv
package tlc_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int ALPHA_BITS = 16;
    localparam int ALPHA_SHR  = 16;
    localparam int TICK_W     = 32;
    localparam int LEAD_W     = TICK_W + 1;
    localparam int SMOOTH_W   = LEAD_W + FRAC_BITS;
    localparam int ERR_W      = SMOOTH_W + 1;
    localparam int PROD_W     = ERR_W + ALPHA_BITS + 1;
    localparam int CFG_W      = 16;
    localparam int COOL_W     = 8;
    localparam int CORR_W     = 17;
    localparam int CFG_IDX_W  = 3;

    localparam logic [COOL_W-1:0]        SINCE_MAX  = '1;
    localparam logic signed [CORR_W-1:0] CORR_UP    = CORR_W'(1);
    localparam logic signed [CORR_W-1:0] CORR_DOWN  = -CORR_W'(1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ALPHA    = 3'd0,
        CFG_TARGET   = 3'd1,
        CFG_SNAP     = 3'd2,
        CFG_MAXC     = 3'd3,
        CFG_COOLDOWN = 3'd4,
        CFG_DEADBAND = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [ALPHA_BITS-1:0]   alpha;
        logic signed [CFG_W-1:0] target;
        logic [CFG_W-1:0]        snap;
        logic [CFG_W-1:0]        maxc;
        logic [COOL_W-1:0]       cool;
        logic [CFG_W-1:0]        dead;
    } t_cfg;

    typedef struct packed {
        logic signed [CORR_W-1:0] correction;
        logic                     ignored;
        logic                     snapped;
        logic signed [TICK_W-1:0] lead_wrap;
        logic                     estimate_valid;
        logic [TICK_W-1:0]        snap_total;
    } t_result;

endpackage

// File: design/tick_lead_clock_corrector.sv
// Tick lead clock corrector.
// Input channel (i_valid/o_ready) carries one observation per transfer:
// i_server_tick and i_acked_tick. An acked tick of zero is reported as
// ignored and leaves the estimate untouched.
// Output channel (o_valid/i_ready) carries one result per observation:
// the correction to apply, ignored/snapped flags, the last raw lead, the
// estimate-valid flag and the running snap count.
// Configuration channel (i_cfg_valid/o_cfg_ready, i_cfg_index, i_cfg_data)
// writes alpha, target lead, snap limit, max correction, cooldown and
// deadband; o_cfg_ready is always high. Write only while no result is pending.
// o_valid rises after the input transfer: one input register, then the
// estimate update, decision and result register in one pass.
// Throughput is one observation per cycle while i_ready stays high; the
// estimate recursion closes within that single pass.
// Reset (synchronous, i_rst_n low) clears the estimate and counters, empties
// both pipeline stages and restores the configuration defaults.
// When i_ready is low the result holds and one more observation can be
// taken into the input register before o_ready drops.
module tick_lead_clock_corrector (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic [tlc_pkg::TICK_W-1:0]           i_server_tick,
    input  logic [tlc_pkg::TICK_W-1:0]           i_acked_tick,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic signed [tlc_pkg::CORR_W-1:0]    o_correction,
    output logic                                 o_ignored,
    output logic                                 o_snapped,
    output logic signed [tlc_pkg::TICK_W-1:0]    o_raw_lead_out,
    output logic                                 o_estimate_valid,
    output logic [tlc_pkg::TICK_W-1:0]           o_snap_total,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [tlc_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [tlc_pkg::CFG_W-1:0]            i_cfg_data
);
    import tlc_pkg::*;

    t_cfg              cfg;
    t_result           result;
    logic              advance;
    logic              commit;

    logic              r_in_valid;
    logic [TICK_W-1:0] r_in_server;
    logic [TICK_W-1:0] r_in_acked;
    logic              r_out_valid;
    t_result           r_out;

    assign advance = !r_out_valid || i_ready;
    assign commit  = r_in_valid && advance;
    assign o_ready = !r_in_valid || advance;

    tlc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_cfg       (cfg)
    );

    tlc_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_commit      (commit),
        .i_server_tick (r_in_server),
        .i_acked_tick  (r_in_acked),
        .o_result      (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_server <= i_server_tick;
            r_in_acked  <= i_acked_tick;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_out <= result;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_correction     = r_out.correction;
    assign o_ignored        = r_out.ignored;
    assign o_snapped        = r_out.snapped;
    assign o_raw_lead_out   = r_out.lead_wrap;
    assign o_estimate_valid = r_out.estimate_valid;
    assign o_snap_total     = r_out.snap_total;

endmodule

// File: design/tlc_cfg.sv
module tlc_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    input  logic [tlc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [tlc_pkg::CFG_W-1:0]     i_cfg_data,
    output logic                          o_cfg_ready,
    output tlc_pkg::t_cfg                 o_cfg
);
    import tlc_pkg::*;

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.alpha  <= ALPHA_BITS'(6554);
            r_cfg.target <= CFG_W'(4);
            r_cfg.snap   <= CFG_W'(32);
            r_cfg.maxc   <= CFG_W'(64);
            r_cfg.cool   <= COOL_W'(4);
            r_cfg.dead   <= CFG_W'(1);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ALPHA:    r_cfg.alpha  <= i_cfg_data;
                CFG_TARGET:   r_cfg.target <= $signed(i_cfg_data);
                CFG_SNAP:     r_cfg.snap   <= i_cfg_data;
                CFG_MAXC:     r_cfg.maxc   <= i_cfg_data;
                CFG_COOLDOWN: r_cfg.cool   <= i_cfg_data[COOL_W-1:0];
                CFG_DEADBAND: r_cfg.dead   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

endmodule

// File: design/tlc_core.sv
module tlc_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  tlc_pkg::t_cfg              i_cfg,
    input  logic                       i_commit,
    input  logic [tlc_pkg::TICK_W-1:0] i_server_tick,
    input  logic [tlc_pkg::TICK_W-1:0] i_acked_tick,
    output tlc_pkg::t_result           o_result
);
    import tlc_pkg::*;

    logic signed [SMOOTH_W-1:0] r_smoothed, n_smoothed;
    logic                       r_have, n_have;
    logic [TICK_W-1:0]          r_last, n_last;
    logic [COOL_W-1:0]          r_since, n_since;
    logic [TICK_W-1:0]          r_snaps, n_snaps;

    logic                       obs;
    logic signed [LEAD_W-1:0]   raw;
    logic signed [SMOOTH_W-1:0] raw_fx;
    logic signed [ERR_W-1:0]    diff;
    logic signed [ALPHA_BITS:0] alpha_s;
    logic signed [PROD_W-1:0]   prod;
    logic signed [SMOOTH_W-1:0] ema;
    logic signed [SMOOTH_W-1:0] est;
    logic signed [SMOOTH_W-1:0] target_fx;
    logic signed [ERR_W-1:0]    err;
    logic                       neg;
    logic [ERR_W-1:0]           mag;
    logic [ERR_W-1:0]           whole;
    logic [CFG_W-1:0]           clamp;
    logic                       is_snap;
    logic                       dead_hit;
    logic                       in_cool;
    logic [COOL_W-1:0]          since_inc;
    logic signed [CORR_W-1:0]   corr;

    assign obs       = (i_acked_tick != '0);
    assign raw       = $signed({1'b0, i_acked_tick}) - $signed({1'b0, i_server_tick});
    assign raw_fx    = $signed({raw, {FRAC_BITS{1'b0}}});
    assign diff      = ERR_W'(raw_fx) - ERR_W'(r_smoothed);
    assign alpha_s   = $signed({1'b0, i_cfg.alpha});
    assign prod      = PROD_W'(diff) * PROD_W'(alpha_s);
    assign ema       = r_smoothed + prod[ALPHA_SHR +: SMOOTH_W];
    assign est       = r_have ? ema : raw_fx;
    assign target_fx = $signed({{(SMOOTH_W - CFG_W - FRAC_BITS){i_cfg.target[CFG_W-1]}},
                                i_cfg.target, {FRAC_BITS{1'b0}}});
    assign err       = ERR_W'(est) - ERR_W'(target_fx);
    assign neg       = err[ERR_W-1];
    assign mag       = neg ? ERR_W'(-err) : ERR_W'(err);
    assign is_snap   = mag >= ERR_W'({i_cfg.snap, {FRAC_BITS{1'b0}}});
    assign dead_hit  = mag > ERR_W'({i_cfg.dead, {FRAC_BITS{1'b0}}});
    assign whole     = mag >> FRAC_BITS;
    assign clamp     = (whole > ERR_W'(i_cfg.maxc)) ? i_cfg.maxc : whole[CFG_W-1:0];
    assign since_inc = (r_since == SINCE_MAX) ? r_since : r_since + COOL_W'(1);
    assign in_cool   = since_inc < i_cfg.cool;

    always_comb begin
        corr    = '0;
        n_since = since_inc;
        if (!obs) begin
            n_since = r_since;
        end else if (is_snap) begin
            corr    = neg ? $signed({1'b0, clamp}) : -$signed({1'b0, clamp});
            n_since = '0;
        end else if (in_cool) begin
            corr = '0;
        end else if (dead_hit) begin
            corr    = neg ? CORR_UP : CORR_DOWN;
            n_since = '0;
        end
    end

    always_comb begin
        n_smoothed = r_smoothed;
        n_have     = r_have;
        n_last     = r_last;
        n_snaps    = r_snaps;
        if (obs) begin
            n_smoothed = is_snap ? target_fx : est;
            n_have     = 1'b1;
            n_last     = raw[TICK_W-1:0];
            n_snaps    = is_snap ? r_snaps + TICK_W'(1) : r_snaps;
        end
    end

    always_comb begin
        o_result.correction     = corr;
        o_result.ignored        = !obs;
        o_result.snapped        = obs && is_snap;
        o_result.lead_wrap      = $signed(n_last);
        o_result.estimate_valid = n_have;
        o_result.snap_total     = n_snaps;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_smoothed <= '0;
            r_have     <= 1'b0;
            r_last     <= '0;
            r_since    <= '0;
            r_snaps    <= '0;
        end else if (i_commit) begin
            r_smoothed <= n_smoothed;
            r_have     <= n_have;
            r_last     <= n_last;
            r_since    <= n_since;
            r_snaps    <= n_snaps;
        end
    end

endmodule

// File: design/tlc_chk.sv
module tlc_chk (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              o_valid,
    input  logic                              i_ready,
    input  logic signed [tlc_pkg::CORR_W-1:0] o_correction,
    input  logic                              o_ignored,
    input  logic                              o_snapped,
    input  logic                              o_estimate_valid
);
    import tlc_pkg::*;

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    a_ignored_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_ignored |-> !o_snapped && o_correction == '0)
        else $error("ignored observation produced a correction");

    a_snap_seeded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_snapped |-> o_estimate_valid)
        else $error("snap without an estimate");

    a_nudge_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_snapped |->
            o_correction == '0 || o_correction == CORR_UP || o_correction == CORR_DOWN)
        else $error("nudge larger than one tick");

    a_hold_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_correction))
        else $error("stalled result changed");

endmodule

bind tick_lead_clock_corrector tlc_chk u_tlc_chk (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_valid          (o_valid),
    .i_ready          (i_ready),
    .o_correction     (o_correction),
    .o_ignored        (o_ignored),
    .o_snapped        (o_snapped),
    .o_estimate_valid (o_estimate_valid)
);
